>>> rtl/core/wrars_pkg.sv
`default_nettype none
package wrars_pkg;

	localparam int unsigned IDX_W = 13;
	localparam int unsigned VAL_W = 40;
	localparam int unsigned WGT_W = 32;
	localparam int unsigned SUM_W = 56;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_CLEAR = 3'd1,
		OP_ADD   = 3'd2,
		OP_QUERY = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef struct packed {
		logic capture;
		logic issue;
		logic wr_weight;
		logic clr_wr;
		logic finish;
		logic err;
	} dp_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/weighted_range_add_range_sum_top.sv
// A range add, query or read walks its elements in order, then waits for the pipeline to drain before done.
// A load weight or a rejected word finishes without the pipeline; clear walks all ELEMENTS addresses.
// Throughput is one operation at a time, set by one element per cycle through the RAM ports.
// After reset the increment RAM is zeroed with busy high.
// Each result is shown for one cycle with done; the receiver cannot stall.
`default_nettype none
module weighted_range_add_range_sum_top
	import wrars_pkg::*;
#(
	parameter int unsigned ELEMENTS = 4096
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [2:0]              operation,
	input  wire logic [IDX_W-1:0]        index_low,
	input  wire logic [IDX_W-1:0]        index_high,
	input  wire logic signed [VAL_W-1:0] add_value,
	input  wire logic [WGT_W-1:0]        weight_value,
	output logic                         done,
	output logic signed [SUM_W-1:0]      sum_result,
	output logic signed [VAL_W-1:0]      element_value,
	output logic                         error
);

	dp_cmd_t                       cmd;
	logic [$clog2(ELEMENTS)-1:0]   addr;
	logic                          pipe_busy;

	wrars_ctrl #(.ELEMENTS(ELEMENTS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.index_low  (index_low),
		.index_high (index_high),
		.pipe_busy  (pipe_busy),
		.busy       (busy),
		.done       (done),
		.addr       (addr),
		.cmd        (cmd)
	);

	wrars_dp #(.ELEMENTS(ELEMENTS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.addr          (addr),
		.operation     (operation),
		.add_value     (add_value),
		.weight_value  (weight_value),
		.pipe_busy     (pipe_busy),
		.sum_result    (sum_result),
		.element_value (element_value),
		.error         (error)
	);

endmodule
`default_nettype wire

>>> rtl/core/wrars_ram.sv
`default_nettype none
module wrars_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

>>> rtl/core/wrars_ctrl.sv
`default_nettype none
module wrars_ctrl
	import wrars_pkg::*;
#(
	parameter int unsigned ELEMENTS = 4096
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [2:0]                  operation,
	input  wire logic [IDX_W-1:0]            index_low,
	input  wire logic [IDX_W-1:0]            index_high,
	input  wire logic                        pipe_busy,
	output logic                             busy,
	output logic                             done,
	output logic [$clog2(ELEMENTS)-1:0]      addr,
	output dp_cmd_t                          cmd
);

	localparam int unsigned AW = $clog2(ELEMENTS);

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_CLEAR, ST_WRW, ST_RUN, ST_DRAIN, ST_FIN, ST_DONE
	} state_t;

	state_t        state_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] last_q;
	logic          err_q;

	logic          lo_ok;
	logic          span_ok;
	logic [AW-1:0] lo_a;
	logic [AW-1:0] hi_a;

	assign lo_ok   = (32'(index_low) >= 32'd1) && (32'(index_low) <= 32'(ELEMENTS));
	assign span_ok = lo_ok && (32'(index_high) <= 32'(ELEMENTS)) && (index_low <= index_high);
	assign lo_a    = AW'(32'(index_low) - 32'd1);
	assign hi_a    = AW'(32'(index_high) - 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			addr_q  <= '0;
			last_q  <= AW'(ELEMENTS - 1);
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (addr_q == last_q) begin
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (start) begin
						err_q <= 1'b0;
						unique case (op_t'(operation))
							OP_LOAD: begin
								if (lo_ok) begin
									addr_q  <= lo_a;
									state_q <= ST_WRW;
								end else begin
									err_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							OP_CLEAR: begin
								addr_q  <= '0;
								last_q  <= AW'(ELEMENTS - 1);
								state_q <= ST_CLEAR;
							end
							OP_ADD, OP_QUERY: begin
								if (span_ok) begin
									addr_q  <= lo_a;
									last_q  <= hi_a;
									state_q <= ST_RUN;
								end else begin
									err_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							OP_READ: begin
								if (lo_ok) begin
									addr_q  <= lo_a;
									last_q  <= lo_a;
									state_q <= ST_RUN;
								end else begin
									err_q   <= 1'b1;
									state_q <= ST_FIN;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_CLEAR: begin
					if (addr_q == last_q) begin
						state_q <= ST_FIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_WRW: begin
					state_q <= ST_FIN;
				end
				ST_RUN: begin
					if (addr_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_DONE);
	assign addr          = addr_q;
	assign cmd.capture   = (state_q == ST_IDLE) && start;
	assign cmd.issue     = (state_q == ST_RUN);
	assign cmd.wr_weight = (state_q == ST_WRW);
	assign cmd.clr_wr    = (state_q == ST_CLEAR) || (state_q == ST_INIT);
	assign cmd.finish    = (state_q == ST_FIN);
	assign cmd.err       = err_q;

endmodule
`default_nettype wire

>>> rtl/core/wrars_dp.sv
`default_nettype none
module wrars_dp
	import wrars_pkg::*;
#(
	parameter int unsigned ELEMENTS = 4096
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dp_cmd_t                       cmd,
	input  wire logic [$clog2(ELEMENTS)-1:0]   addr,
	input  wire logic [2:0]                    operation,
	input  wire logic signed [VAL_W-1:0]       add_value,
	input  wire logic [WGT_W-1:0]              weight_value,
	output logic                               pipe_busy,
	output logic signed [SUM_W-1:0]            sum_result,
	output logic signed [VAL_W-1:0]            element_value,
	output logic                               error
);

	localparam int unsigned AW    = $clog2(ELEMENTS);
	localparam int unsigned TERM_W = 58;
	localparam int unsigned ACC_W = TERM_W + AW;

	logic [2:0]              op_q;
	logic signed [VAL_W-1:0] val_q;
	logic [WGT_W-1:0]        wgt_q;

	logic                    valid_s1, valid_s2, valid_s3;
	logic [AW-1:0]           addr_s1;
	logic signed [56:0]      p_hi_s2;
	logic [47:0]             p_lo_s2;
	logic signed [TERM_W-1:0] term_s3;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [VAL_W-1:0] elem_q;

	logic signed [SUM_W-1:0] sum_out_q;
	logic signed [VAL_W-1:0] elem_out_q;
	logic                    err_out_q;

	logic [WGT_W-1:0]        w_rd;
	logic signed [VAL_W-1:0] inc_rd;
	logic signed [VAL_W:0]   inc_sum;
	logic signed [VAL_W-1:0] inc_sat;
	logic                    inc_we;
	logic [AW-1:0]           inc_waddr;
	logic [VAL_W-1:0]        inc_wdata;
	logic [VAL_W-1:0]        inc_rdata;
	logic                    acc_fits;
	logic signed [SUM_W-1:0] acc_sat;

	wrars_ram #(.WIDTH(WGT_W), .DEPTH(ELEMENTS)) u_wgt_ram (
		.clk   (clk),
		.we    (cmd.wr_weight),
		.waddr (addr),
		.wdata (wgt_q),
		.raddr (addr),
		.rdata (w_rd)
	);

	wrars_ram #(.WIDTH(VAL_W), .DEPTH(ELEMENTS)) u_inc_ram (
		.clk   (clk),
		.we    (inc_we),
		.waddr (inc_waddr),
		.wdata (inc_wdata),
		.raddr (addr),
		.rdata (inc_rdata)
	);

	assign inc_rd  = $signed(inc_rdata);
	assign inc_sum = {inc_rd[VAL_W-1], inc_rd} + {val_q[VAL_W-1], val_q};

	always_comb begin
		if (inc_sum[VAL_W] != inc_sum[VAL_W-1]) begin
			inc_sat = inc_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			inc_sat = inc_sum[VAL_W-1:0];
		end
	end

	assign inc_we    = cmd.clr_wr || (valid_s1 && (op_q == OP_ADD));
	assign inc_waddr = cmd.clr_wr ? addr : addr_s1;
	assign inc_wdata = cmd.clr_wr ? '0 : inc_sat;

	assign acc_fits = (&acc_q[ACC_W-1:SUM_W-1]) || !(|acc_q[ACC_W-1:SUM_W-1]);

	always_comb begin
		if (acc_fits) begin
			acc_sat = acc_q[SUM_W-1:0];
		end else if (acc_q[ACC_W-1]) begin
			acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			val_q <= add_value;
			wgt_q <= weight_value;
		end
		addr_s1 <= addr;
		if (valid_s1 && (op_q == OP_READ)) begin
			elem_q <= inc_rd;
		end
		p_hi_s2 <= $signed({1'b0, w_rd}) * $signed(inc_rd[VAL_W-1:16]);
		p_lo_s2 <= w_rd * inc_rd[15:0];
		term_s3 <= {p_hi_s2[56], p_hi_s2} + {26'b0, p_lo_s2[47:16]};
		if (cmd.capture) begin
			acc_q <= '0;
		end else if (valid_s3) begin
			acc_q <= acc_q + {{(ACC_W-TERM_W){term_s3[TERM_W-1]}}, term_s3};
		end
		if (cmd.finish) begin
			sum_out_q  <= (op_q == OP_QUERY && !cmd.err) ? acc_sat : '0;
			elem_out_q <= (op_q == OP_READ && !cmd.err) ? elem_q : '0;
			err_out_q  <= cmd.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign pipe_busy     = valid_s1 || valid_s2 || valid_s3;
	assign sum_result    = sum_out_q;
	assign element_value = elem_out_q;
	assign error         = err_out_q;

endmodule
`default_nettype wire
